// ===== rtl/vps_pkg.sv =====
// Shared types, constants and helpers for the vertex projection block.
`default_nettype none
package vps_pkg;
  localparam int VTX_W      = 32;
  localparam int COEF_W     = 21;
  localparam int ACC_W      = 56;
  localparam int REM_W      = 88;
  localparam int VP_W       = 13;
  localparam int GROUP_W    = 63;
  localparam int NUM_GROUPS = 6;
  localparam int CFG_DW     = 64;
  localparam int CFG_AW     = 6;
  localparam int SCR_W      = 48;

  localparam logic [2:0] REG_COEF0 = 3'd0;
  localparam logic [2:0] REG_COEF1 = 3'd1;
  localparam logic [2:0] REG_COEF2 = 3'd2;
  localparam logic [2:0] REG_COEF3 = 3'd3;
  localparam logic [2:0] REG_COEF4 = 3'd4;
  localparam logic [2:0] REG_COEF5 = 3'd5;
  localparam logic [2:0] REG_VP_W  = 3'd6;
  localparam logic [2:0] REG_VP_H  = 3'd7;

  typedef struct packed {
    logic [NUM_GROUPS-1:0][GROUP_W-1:0] coef_group;
    logic [VP_W-1:0]                    vp_width;
    logic [VP_W-1:0]                    vp_height;
  } vps_cfg_t;

  typedef struct packed {
    logic [2:0][ACC_W-1:0] num_mag;
    logic [ACC_W-1:0]      den_mag;
    logic [2:0]            neg;
    logic                  near0;
    logic [2:0][VTX_W-1:0] vert;
  } vps_frac_t;

  typedef struct packed {
    logic [2:0][VTX_W-1:0] clip;
    logic                  near0;
  } vps_clip_t;

  function automatic logic [VTX_W-1:0] sat32(input logic signed [SCR_W-1:0] v);
    logic signed [SCR_W-1:0] hi;
    logic signed [SCR_W-1:0] lo;
    hi = SCR_W'(signed'(32'sh7FFFFFFF));
    lo = SCR_W'(signed'(32'sh80000000));
    if (v > hi) begin
      sat32 = 32'h7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'h80000000;
    end else begin
      sat32 = v[VTX_W-1:0];
    end
  endfunction
endpackage
`default_nettype wire

// ===== rtl/vps_if.sv =====
// Item channels for vertices in and projected results out.
`default_nettype none
interface vps_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;
  modport source(output valid, output vertex_x, output vertex_y, output vertex_z, input ready);
  modport sink(input valid, input vertex_x, input vertex_y, input vertex_z, output ready);
endinterface

interface vps_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] depth_z;
  logic signed [31:0] clip_x;
  logic signed [31:0] clip_y;
  logic signed [31:0] clip_z;
  logic              w_near_zero;
  modport source(output valid, output screen_x, output screen_y, output depth_z,
                 output clip_x, output clip_y, output clip_z, output w_near_zero,
                 input ready);
  modport sink(input valid, input screen_x, input screen_y, input depth_z,
               input clip_x, input clip_y, input clip_z, input w_near_zero,
               output ready);
endinterface
`default_nettype wire

// ===== rtl/vps_regs.sv =====
// APB configuration registers: matrix coefficient groups and viewport size.
`default_nettype none
module vps_regs (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [5:0]               paddr,
  input  logic [63:0]              pwdata,
  output logic [63:0]              prdata,
  output logic                     pready,
  output vps_pkg::vps_cfg_t        cfg
);
  import vps_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_group[0] <= 63'd4096;
      cfg.coef_group[1] <= 63'd18014398509481984;
      cfg.coef_group[2] <= 63'd0;
      cfg.coef_group[3] <= 63'd8589934592;
      cfg.coef_group[4] <= 63'd0;
      cfg.coef_group[5] <= 63'd4096;
      cfg.vp_width      <= 13'd320;
      cfg.vp_height     <= 13'd240;
    end else if (wr) begin
      case (idx)
        REG_VP_W: cfg.vp_width  <= pwdata[VP_W-1:0];
        REG_VP_H: cfg.vp_height <= pwdata[VP_W-1:0];
        default:  cfg.coef_group[idx] <= pwdata[GROUP_W-1:0];
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_VP_W: prdata = {51'd0, cfg.vp_width};
      REG_VP_H: prdata = {51'd0, cfg.vp_height};
      default:  prdata = {1'b0, cfg.coef_group[idx]};
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/vps_xform.sv =====
// Matrix transform: products, dot-product sums, sign/magnitude and near-zero w test.
`default_nettype none
module vps_xform #(
  parameter int VERTEX_FRAC_BITS = 16,
  parameter int COEF_FRAC_BITS   = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  vps_pkg::vps_cfg_t     cfg,
  vps_in_if.sink                in_ch,
  output logic                  out_valid,
  input  logic                  out_ready,
  output vps_pkg::vps_frac_t    out_data
);
  import vps_pkg::*;

  localparam logic [ACC_W-1:0] THR =
    ACC_W'(((64'd1 << (VERTEX_FRAC_BITS + COEF_FRAC_BITS)) + 64'd9999) / 64'd10000);

  logic [3:0] v;
  logic [3:0] en;

  logic signed [COEF_W-1:0] m [16];

  logic [2:0][VTX_W-1:0] vt0, vt1, vt2;
  logic signed [ACC_W-1:0] prod [3][4];
  logic signed [ACC_W-1:0] bias [4];
  logic signed [ACC_W-1:0] acc  [4];

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int f = 0; f < 3; f++) begin
        if (g * 3 + f < 16) begin
          m[g*3+f] = cfg.coef_group[g][f*COEF_W +: COEF_W];
        end
      end
    end
  end

  assign en[3]        = !v[3] || out_ready;
  assign en[2]        = !v[2] || en[3];
  assign en[1]        = !v[1] || en[2];
  assign en[0]        = !v[0] || en[1];
  assign in_ch.ready  = en[0];
  assign out_valid    = v[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_ch.valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      vt0 <= {in_ch.vertex_z, in_ch.vertex_y, in_ch.vertex_x};
    end
    if (en[1]) begin
      vt1 <= vt0;
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 4; c++) begin
          prod[k][c] <= ACC_W'($signed(vt0[k]) * m[4*k+c]);
        end
      end
      for (int c = 0; c < 4; c++) begin
        bias[c] <= ACC_W'(m[12+c]) <<< VERTEX_FRAC_BITS;
      end
    end
    if (en[2]) begin
      vt2 <= vt1;
      for (int c = 0; c < 4; c++) begin
        acc[c] <= prod[0][c] + prod[1][c] + prod[2][c] + bias[c];
      end
    end
    if (en[3]) begin
      out_data.vert <= vt2;
      out_data.den_mag <= acc[3][ACC_W-1] ? ACC_W'(-acc[3]) : ACC_W'(acc[3]);
      out_data.near0 <= (acc[3][ACC_W-1] ? ACC_W'(-acc[3]) : ACC_W'(acc[3])) < THR;
      for (int k = 0; k < 3; k++) begin
        out_data.num_mag[k] <= acc[k][ACC_W-1] ? ACC_W'(-acc[k]) : ACC_W'(acc[k]);
        out_data.neg[k]     <= acc[k][ACC_W-1] ^ acc[3][ACC_W-1];
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/vps_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, three lanes sharing w.
`default_nettype none
module vps_div #(
  parameter int VERTEX_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vps_pkg::vps_frac_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vps_pkg::vps_clip_t   out_data
);
  import vps_pkg::*;

  localparam int QB  = VTX_W;
  localparam int NST = QB + 2;

  logic [NST-1:0] v;
  logic [NST:0]   en;

  logic [REM_W-1:0]      rm   [NST-1][3];
  logic [QB-1:0]         qt   [NST-1][3];
  logic [2:0]            ovf  [NST-1];
  logic [2:0]            ng   [NST-1];
  logic                  nz   [NST-1];
  logic [ACC_W-1:0]      dd   [NST-1];
  logic [2:0][VTX_W-1:0] vt   [NST-1];

  logic [2:0] neg_out;
  logic [2:0] ovf_out;

  assign en[NST]   = out_ready;
  assign in_ready  = en[0];
  assign out_valid = v[NST-1];

  genvar s;
  generate
    for (s = 0; s < NST; s++) begin : g_en
      assign en[s] = !v[s] || en[s+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dd[0] <= in_data.den_mag;
      ng[0] <= in_data.neg;
      nz[0] <= in_data.near0;
      vt[0] <= in_data.vert;
      for (int k = 0; k < 3; k++) begin
        rm[0][k]  <= REM_W'(in_data.num_mag[k]) << VERTEX_FRAC_BITS;
        qt[0][k]  <= '0;
        ovf[0][k] <= (REM_W'(in_data.num_mag[k]) << VERTEX_FRAC_BITS)
                     >= (REM_W'(in_data.den_mag) << QB);
      end
    end
  end

  generate
    for (s = 1; s <= QB; s++) begin : g_bit
      logic [REM_W-1:0] dsh;
      assign dsh = REM_W'(dd[s-1]) << (QB - s);
      always_ff @(posedge clk) begin
        if (en[s]) begin
          dd[s]  <= dd[s-1];
          ng[s]  <= ng[s-1];
          nz[s]  <= nz[s-1];
          vt[s]  <= vt[s-1];
          ovf[s] <= ovf[s-1];
          for (int k = 0; k < 3; k++) begin
            if (rm[s-1][k] >= dsh) begin
              rm[s][k] <= rm[s-1][k] - dsh;
              qt[s][k] <= qt[s-1][k] | (QB'(1) << (QB - s));
            end else begin
              rm[s][k] <= rm[s-1][k];
              qt[s][k] <= qt[s-1][k];
            end
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    logic [QB-1:0] lim;
    logic [QB-1:0] mg;
    if (en[NST-1]) begin
      out_data.near0 <= nz[QB];
      neg_out        <= ng[QB];
      ovf_out        <= ovf[QB];
      for (int k = 0; k < 3; k++) begin
        lim = ng[QB][k] ? 32'h80000000 : 32'h7FFFFFFF;
        mg  = (ovf[QB][k] || qt[QB][k] > lim) ? lim : qt[QB][k];
        if (nz[QB]) begin
          out_data.clip[k] <= vt[QB][k];
        end else begin
          out_data.clip[k] <= ng[QB][k] ? QB'(-mg) : mg;
        end
      end
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("divider output valid after reset");
  a_sign: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.near0 && !neg_out[0]) |-> !out_data.clip[0][VTX_W-1])
    else $error("positive quotient has sign bit set");
  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.near0 && ovf_out[1]) |->
      (out_data.clip[1] == (neg_out[1] ? 32'h80000000 : 32'h7FFFFFFF)))
    else $error("overflowed quotient not saturated");
endmodule
`default_nettype wire

// ===== rtl/vps_view.sv =====
// Viewport mapping: scale clip x,y by the screen size, offset by half (y inverted), saturate.
`default_nettype none
module vps_view #(
  parameter int VERTEX_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  vps_pkg::vps_cfg_t   cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  vps_pkg::vps_clip_t  in_data,
  vps_out_if.source           out_ch
);
  import vps_pkg::*;

  logic [1:0] v;
  logic [1:0] en;
  vps_clip_t  c0;
  logic signed [SCR_W-1:0] px;
  logic signed [SCR_W-1:0] py;
  logic signed [SCR_W-1:0] hw;
  logic signed [SCR_W-1:0] hh;

  assign hw = $signed(SCR_W'(cfg.vp_width))  <<< (VERTEX_FRAC_BITS - 1);
  assign hh = $signed(SCR_W'(cfg.vp_height)) <<< (VERTEX_FRAC_BITS - 1);

  assign en[1]        = !v[1] || out_ch.ready;
  assign en[0]        = !v[0] || en[1];
  assign in_ready     = en[0];
  assign out_ch.valid = v[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c0 <= in_data;
      px <= SCR_W'($signed(in_data.clip[0]) * $signed({1'b0, cfg.vp_width}));
      py <= SCR_W'($signed(in_data.clip[1]) * $signed({1'b0, cfg.vp_height}));
    end
    if (en[1]) begin
      out_ch.screen_x    <= sat32(px + hw);
      out_ch.screen_y    <= sat32(hh - py);
      out_ch.depth_z     <= c0.clip[2];
      out_ch.clip_x      <= c0.clip[0];
      out_ch.clip_y      <= c0.clip[1];
      out_ch.clip_z      <= c0.clip[2];
      out_ch.w_near_zero <= c0.near0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/vertex_project_to_screen.sv =====
// Top level of the vertex projection block.
// Each accepted vertex (x, y, z) is multiplied as (x, y, z, 1) by the configured 4x4
// matrix, divided by w and mapped to the viewport; one result item per vertex, in order.
// A new vertex is taken every clock unless stalled; it passes 4 transform stages, 34 divider
// stages (one quotient bit per stage across three lanes) and 2 viewport stages. Stalls
// back up stage by stage, and bubbles are squeezed out. When |w| < 0.0001 the vertex is
// passed through as clip coordinates and w_near_zero is set. Registers sit at byte
// address 8*i on the 64-bit APB port and should be written only while the pipeline is empty.
`default_nettype none
module vertex_project_to_screen #(
  parameter int VERTEX_FRAC_BITS = 16,
  parameter int COEF_FRAC_BITS   = 12
) (
  input  logic         clk,
  input  logic         rst,
  vps_in_if.sink       in_ch,
  vps_out_if.source    out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import vps_pkg::*;

  vps_cfg_t  cfg;
  logic      xf_valid, xf_ready;
  vps_frac_t xf_data;
  logic      dv_valid, dv_ready;
  vps_clip_t dv_data;

  vps_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  vps_xform #(
    .VERTEX_FRAC_BITS(VERTEX_FRAC_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_xform (
    .clk, .rst, .cfg, .in_ch,
    .out_valid(xf_valid), .out_ready(xf_ready), .out_data(xf_data)
  );

  vps_div #(.VERTEX_FRAC_BITS(VERTEX_FRAC_BITS)) u_div (
    .clk, .rst,
    .in_valid(xf_valid), .in_ready(xf_ready), .in_data(xf_data),
    .out_valid(dv_valid), .out_ready(dv_ready), .out_data(dv_data)
  );

  vps_view #(.VERTEX_FRAC_BITS(VERTEX_FRAC_BITS)) u_view (
    .clk, .rst, .cfg,
    .in_valid(dv_valid), .in_ready(dv_ready), .in_data(dv_data), .out_ch
  );
endmodule
`default_nettype wire
